// File: hw/rtl/kdsl_pkg.sv
// Shared types and constants for the key debounce and press detector.
package kdsl_pkg;

  // Fixed widths of the register fields and stream fields.
  localparam int THR_W      = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE_TICKS    = 2'd0,
    REG_LONG_PRESS_TICKS  = 2'd1,
    REG_ACTIVE_LEVEL_MASK = 2'd2,
    REG_KEY_ENABLE_MASK   = 2'd3
  } cfg_reg_e;

  // Per-key phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_PRESSED  = 4'b0100,
    PH_LONG     = 4'b1000
  } key_phase_t;

  // Thresholds shared by every key lane.
  typedef struct packed {
    logic [THR_W-1:0] debounce_ticks;
    logic [THR_W-1:0] long_press_ticks;
  } thr_cfg_t;

  // Events from one key lane for the current item.
  typedef struct packed {
    logic short_press;
    logic long_press;
  } key_ev_t;

endpackage

// File: hw/rtl/kdsl_key.sv
// One key lane: phase machine and saturating hold counter.
module kdsl_key #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               enable,
  input  logic               held,
  input  kdsl_pkg::thr_cfg_t thr,
  output kdsl_pkg::key_ev_t  ev
);
  import kdsl_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  key_phase_t             phase;
  key_phase_t             phase_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   deb_met;
  logic                   long_met;
  logic                   short_raw;
  logic                   long_raw;

  // Saturating increment and threshold compares on the incremented count.
  assign count_inc = (count == {COUNT_WIDTH{1'b1}}) ? count : count + COUNT_WIDTH'(1);
  assign deb_met   = CMP_W'(count_inc) >= CMP_W'(thr.debounce_ticks);
  assign long_met  = CMP_W'(count_inc) >= CMP_W'(thr.long_press_ticks);

  // Next phase, next count and events for this item.
  always_comb begin
    phase_next = phase;
    count_next = count;
    short_raw  = 1'b0;
    long_raw   = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (held) begin
          phase_next = PH_DEBOUNCE;
          count_next = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (held) begin
          count_next = count_inc;
          if (deb_met) begin
            phase_next = PH_PRESSED;
            count_next = '0;
          end
        end else begin
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      PH_PRESSED: begin
        if (held) begin
          count_next = count_inc;
          if (long_met) begin
            long_raw   = 1'b1;
            phase_next = PH_LONG;
          end
        end else begin
          short_raw  = 1'b1;
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      PH_LONG: begin
        if (!held) begin
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        count_next = '0;
      end
    endcase
  end

  // A disabled key keeps its state and raises no events.
  assign ev.short_press = enable & short_raw;
  assign ev.long_press  = enable & long_raw;

  // State update on each accepted item for an enabled key.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else if (step && enable) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

// File: hw/rtl/kdsl_out.sv
// Result register between the key lanes and the output stream.
module kdsl_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [kdsl_pkg::MASK_W-1:0]     short_events,
  input  logic [kdsl_pkg::MASK_W-1:0]     long_events,
  output logic                            can_load,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kdsl_pkg::OUT_DATA_W-1:0] m_tdata
);
  import kdsl_pkg::*;

  // A new item may enter when the register is empty or is being drained.
  assign can_load = !m_tvalid || m_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  // Payload: short events low, long events high.
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      m_tdata <= {long_events, short_events};
    end
  end

endmodule

// File: hw/rtl/key_debounce_short_long_press.sv
// Top level of the key debounce and short/long press detector.
// Each input item is one scan tick holding the raw pin level of up to eight keys; each
// result item holds the short-press and long-press event bits of that tick. A key is held
// when its pin matches its bit in the active-level register, and only keys set in the
// enable register advance. The block takes one item per clock cycle unless the output stalls,
// and delivers its result in the next cycle from a single result register; every key lane
// updates its phase and hold counter as the item is accepted. Keys at index eight and up have
// no pin or mask bit and stay idle. Configuration registers reset to 20, 1000, 0 and 0.
module key_debounce_short_long_press #(
  parameter int NUM_KEYS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream; s_tdata: pin_levels [7:0].
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kdsl_pkg::IN_DATA_W-1:0]    s_tdata,
  // Output stream; m_tdata: short_press_events [7:0], long_press_events [15:8].
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kdsl_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [kdsl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kdsl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kdsl_pkg::*;

  localparam int LIVE_KEYS = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;

  thr_cfg_t              thr;
  logic [MASK_W-1:0]     active_level_mask;
  logic [MASK_W-1:0]     key_enable_mask;
  logic                  accept;
  logic [MASK_W-1:0]     short_events;
  logic [MASK_W-1:0]     long_events;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.debounce_ticks   <= THR_W'(20);
      thr.long_press_ticks <= THR_W'(1000);
      active_level_mask    <= '0;
      key_enable_mask      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE_TICKS:    thr.debounce_ticks   <= cfg_wdata[THR_W-1:0];
        REG_LONG_PRESS_TICKS:  thr.long_press_ticks <= cfg_wdata[THR_W-1:0];
        REG_ACTIVE_LEVEL_MASK: active_level_mask    <= cfg_wdata[MASK_W-1:0];
        REG_KEY_ENABLE_MASK:   key_enable_mask      <= cfg_wdata[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  // Key lanes; event bits without a lane read as zero.
  for (genvar k = 0; k < MASK_W; k++) begin : g_key
    if (k < LIVE_KEYS) begin : g_live
      key_ev_t ev;

      kdsl_key #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_key (
        .clk    (clk),
        .rst    (rst),
        .step   (accept),
        .enable (key_enable_mask[k]),
        .held   (s_tdata[k] == active_level_mask[k]),
        .thr    (thr),
        .ev     (ev)
      );

      assign short_events[k] = ev.short_press;
      assign long_events[k]  = ev.long_press;
    end else begin : g_none
      assign short_events[k] = 1'b0;
      assign long_events[k]  = 1'b0;
    end
  end

  // Result register and output handshake.
  kdsl_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .short_events (short_events),
    .long_events  (long_events),
    .can_load     (s_tready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule
